// ----- hdl/pprs_pkg.sv -----
`timescale 1ns / 1ps

package pprs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = PTR_W + 1;
  localparam int TAG_W       = 16;
  localparam int LVL_W       = 2;
  localparam int NUM_FIFOS   = 3;
  localparam int FIFO_IDX_W  = 2;

  typedef logic [TAG_W-1:0]      tag_t;
  typedef logic [LVL_W-1:0]      level_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [FIFO_IDX_W-1:0] fifo_idx_t;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam level_t LVL_HIGHEST    = 2'd0;
  localparam level_t LVL_HIGH       = 2'd1;
  localparam level_t LVL_NORMAL     = 2'd2;
  localparam level_t LVL_BACKGROUND = 2'd3;

  localparam fifo_idx_t FIFO_HIGHEST = 2'd0;
  localparam fifo_idx_t FIFO_HIGH    = 2'd1;
  localparam fifo_idx_t FIFO_NORMAL  = 2'd2;

endpackage

// ----- hdl/preemptive_priority_request_scheduler.sv -----
`timescale 1ns / 1ps
// Four-level request scheduler. A beat on the request channel is either a submit
// (tag at level highest, high, normal or background) or a tick carrying the
// handler status; each request beat yields exactly one response beat with the
// cancel, drop, overflow and dispatch flags plus the active level after the beat.
// Highest, high and normal tags wait in QUEUE_DEPTH-entry ring buffers held in
// flip-flops; background keeps a single tag that is restarted on every idle tick.
// One request beat is taken per clock unless a held response stalls the input
// register; a beat passes the input register and the scheduling logic, and its
// response is then registered in the output register. The output register can hold
// one response while the next beat waits in the input register.

module preemptive_priority_request_scheduler
  import pprs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,

  input  logic             req_valid,
  output logic             req_stall,
  input  logic             operation,
  input  logic [LVL_W-1:0] priority_req,
  input  logic [TAG_W-1:0] request_tag,
  input  logic             handlers_done,

  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic             cancel_running,
  output logic             dropped,
  output logic             overflow,
  output logic             dispatch_valid,
  output logic [TAG_W-1:0] dispatch_tag,
  output logic [LVL_W-1:0] active_level,
  output logic             idle
);

  // Input register.
  logic   s1_valid;
  logic   s1_op;
  level_t s1_prio;
  tag_t   s1_tag;
  logic   s1_hdone;

  // Scheduler state.
  tag_t   fifo_mem [NUM_FIFOS][QUEUE_DEPTH];
  ptr_t   heads [NUM_FIFOS];
  count_t counts [NUM_FIFOS];
  tag_t   bg_tag;
  logic   bg_present;
  level_t level;
  logic   all_done;

  ptr_t   heads_next [NUM_FIFOS];
  count_t counts_next [NUM_FIFOS];
  tag_t   bg_tag_next;
  logic   bg_present_next;
  level_t level_next;
  logic   all_done_next;

  logic      try_push;
  logic      push_en;
  fifo_idx_t push_q;
  ptr_t      tail;
  logic [SUM_W-1:0] tail_sum;
  logic      pop_en;
  fifo_idx_t pop_q;

  logic cancel_c;
  logic drop_c;
  logic ovf_c;
  logic dvalid_c;
  tag_t dtag_c;

  logic advance;
  logic accept;

  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= operation;
      s1_prio  <= priority_req;
      s1_tag   <= request_tag;
      s1_hdone <= handlers_done;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_FIFOS; i++) begin
      heads_next[i]  = heads[i];
      counts_next[i] = counts[i];
    end
    bg_tag_next     = bg_tag;
    bg_present_next = bg_present;
    level_next      = level;
    all_done_next   = all_done;
    try_push = 1'b0;
    push_en  = 1'b0;
    push_q   = FIFO_HIGHEST;
    pop_en   = 1'b0;
    pop_q    = FIFO_HIGHEST;
    cancel_c = 1'b0;
    drop_c   = 1'b0;
    ovf_c    = 1'b0;
    dvalid_c = 1'b0;
    dtag_c   = '0;

    if (s1_op == OP_SUBMIT) begin
      if (s1_prio == LVL_HIGHEST) begin
        heads_next[FIFO_HIGH]   = '0;
        counts_next[FIFO_HIGH]  = '0;
        heads_next[FIFO_NORMAL] = '0;
        counts_next[FIFO_NORMAL] = '0;
        bg_tag_next     = '0;
        bg_present_next = 1'b0;
        cancel_c = 1'b1;
        try_push = 1'b1;
        push_q   = FIFO_HIGHEST;
      end else if (level == LVL_HIGHEST) begin
        drop_c = 1'b1;
      end else if (s1_prio == LVL_HIGH) begin
        cancel_c = (level != LVL_HIGH);
        try_push = 1'b1;
        push_q   = FIFO_HIGH;
      end else if (s1_prio == LVL_NORMAL) begin
        try_push = 1'b1;
        push_q   = FIFO_NORMAL;
      end else begin
        bg_tag_next     = s1_tag;
        bg_present_next = 1'b1;
      end

      if (try_push) begin
        if (counts[push_q] == count_t'(QUEUE_DEPTH)) begin
          drop_c = 1'b1;
          ovf_c  = 1'b1;
        end else begin
          push_en = 1'b1;
          counts_next[push_q] = counts[push_q] + count_t'(1);
        end
      end
    end else begin
      all_done_next = s1_hdone;
      if (s1_hdone) begin
        if (counts[FIFO_HIGHEST] != '0) begin
          pop_en     = 1'b1;
          pop_q      = FIFO_HIGHEST;
          level_next = LVL_HIGHEST;
        end else if (counts[FIFO_HIGH] != '0) begin
          pop_en     = 1'b1;
          pop_q      = FIFO_HIGH;
          level_next = LVL_HIGH;
        end else if (counts[FIFO_NORMAL] != '0) begin
          pop_en     = 1'b1;
          pop_q      = FIFO_NORMAL;
          level_next = LVL_NORMAL;
        end else begin
          level_next = LVL_BACKGROUND;
          if (bg_present) begin
            dvalid_c = 1'b1;
            dtag_c   = bg_tag;
          end
        end

        if (pop_en) begin
          dvalid_c = 1'b1;
          dtag_c   = fifo_mem[pop_q][heads[pop_q]];
          if (heads[pop_q] == ptr_t'(QUEUE_DEPTH - 1)) begin
            heads_next[pop_q] = '0;
          end else begin
            heads_next[pop_q] = heads[pop_q] + ptr_t'(1);
          end
          counts_next[pop_q] = counts[pop_q] - count_t'(1);
        end
      end
    end
  end

  // Write slot is head plus count, wrapped once around the ring.
  always_comb begin
    tail_sum = SUM_W'(heads[push_q]) + SUM_W'(counts[push_q]);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (advance && push_en) begin
      fifo_mem[push_q][tail] <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FIFOS; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
      bg_tag     <= '0;
      bg_present <= 1'b0;
      level      <= LVL_BACKGROUND;
      all_done   <= 1'b1;
    end else if (advance) begin
      for (int i = 0; i < NUM_FIFOS; i++) begin
        heads[i]  <= heads_next[i];
        counts[i] <= counts_next[i];
      end
      bg_tag     <= bg_tag_next;
      bg_present <= bg_present_next;
      level      <= level_next;
      all_done   <= all_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cancel_running <= cancel_c;
      dropped        <= drop_c;
      overflow       <= ovf_c;
      dispatch_valid <= dvalid_c;
      dispatch_tag   <= dtag_c;
      active_level   <= level_next;
      idle           <= all_done_next;
    end
  end

endmodule

// ----- sim/preemptive_priority_request_scheduler_tb.sv -----
`timescale 1ns / 1ps

module preemptive_priority_request_scheduler_tb;
  import pprs_pkg::*;

  typedef struct packed {
    logic   cancel;
    logic   drop;
    logic   ovf;
    logic   dvalid;
    tag_t   dtag;
    level_t lvl;
    logic   idle;
  } sched_result_t;

  localparam int OWED_DEPTH = 4;

  // Tracks the scheduler state beat by beat and holds the responses still owed.
  class sched_tracker;
    tag_t          ring[NUM_FIFOS][QUEUE_DEPTH];
    int            head[NUM_FIFOS];
    int            count[NUM_FIFOS];
    tag_t          bg_tag;
    bit            bg_present;
    level_t        level;
    bit            done;
    sched_result_t owed[OWED_DEPTH];
    int            owed_wr;
    int            owed_rd;
    int            errors;

    function new();
      foreach (head[i]) begin
        head[i] = 0;
        count[i] = 0;
      end
      bg_tag = '0;
      bg_present = 0;
      level = LVL_BACKGROUND;
      done = 1;
      owed_wr = 0;
      owed_rd = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed_wr - owed_rd;
    endfunction

    function bit push_tag(int q, tag_t tag);
      if (count[q] >= QUEUE_DEPTH) return 0;
      ring[q][(head[q] + count[q]) % QUEUE_DEPTH] = tag;
      count[q]++;
      return 1;
    endfunction

    function tag_t pop_tag(int q);
      tag_t t;
      t = ring[q][head[q]];
      head[q] = (head[q] + 1) % QUEUE_DEPTH;
      count[q]--;
      return t;
    endfunction

    function void note_request(logic op, level_t prio, tag_t tag, logic hdone);
      sched_result_t r;
      r = '0;
      if (op == OP_SUBMIT) begin
        if (prio == LVL_HIGHEST) begin
          // A highest submit wipes out all lower pending work, even when it overflows.
          head[FIFO_HIGH] = 0;
          count[FIFO_HIGH] = 0;
          head[FIFO_NORMAL] = 0;
          count[FIFO_NORMAL] = 0;
          bg_tag = '0;
          bg_present = 0;
          r.cancel = 1;
          if (!push_tag(FIFO_HIGHEST, tag)) begin
            r.drop = 1;
            r.ovf = 1;
          end
        end else if (level == LVL_HIGHEST) begin
          r.drop = 1;
        end else if (prio == LVL_HIGH) begin
          r.cancel = (level != LVL_HIGH);
          if (!push_tag(FIFO_HIGH, tag)) begin
            r.drop = 1;
            r.ovf = 1;
          end
        end else if (prio == LVL_NORMAL) begin
          if (!push_tag(FIFO_NORMAL, tag)) begin
            r.drop = 1;
            r.ovf = 1;
          end
        end else begin
          bg_tag = tag;
          bg_present = 1;
        end
      end else begin
        done = hdone;
        if (done) begin
          if (count[FIFO_HIGHEST] != 0) begin
            r.dvalid = 1;
            r.dtag = pop_tag(FIFO_HIGHEST);
            level = LVL_HIGHEST;
          end else if (count[FIFO_HIGH] != 0) begin
            r.dvalid = 1;
            r.dtag = pop_tag(FIFO_HIGH);
            level = LVL_HIGH;
          end else if (count[FIFO_NORMAL] != 0) begin
            r.dvalid = 1;
            r.dtag = pop_tag(FIFO_NORMAL);
            level = LVL_NORMAL;
          end else begin
            level = LVL_BACKGROUND;
            if (bg_present) begin
              r.dvalid = 1;
              r.dtag = bg_tag;
            end
          end
        end
      end
      r.lvl = level;
      r.idle = done;
      owed[owed_wr % OWED_DEPTH] = r;
      owed_wr++;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_response(sched_result_t got);
      sched_result_t want;
      if (owed_wr == owed_rd) begin
        errors++;
        $display("%0t: response beat with no request outstanding", $time);
        return;
      end
      want = owed[owed_rd % OWED_DEPTH];
      owed_rd++;
      compare_field("cancel_running", int'(want.cancel), int'(got.cancel));
      compare_field("dropped", int'(want.drop), int'(got.drop));
      compare_field("overflow", int'(want.ovf), int'(got.ovf));
      compare_field("dispatch_valid", int'(want.dvalid), int'(got.dvalid));
      compare_field("dispatch_tag", int'(want.dtag), int'(got.dtag));
      compare_field("active_level", int'(want.lvl), int'(got.lvl));
      compare_field("idle", int'(want.idle), int'(got.idle));
    endfunction
  endclass

  localparam int QUIET_LIMIT = 1000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         req_valid = 1'b0;
  logic         req_stall;
  logic         operation = OP_SUBMIT;
  level_t       priority_req = LVL_HIGHEST;
  tag_t         request_tag = '0;
  logic         handlers_done = 1'b0;
  logic         rsp_valid;
  logic         rsp_stall = 1'b0;
  logic         cancel_running;
  logic         dropped;
  logic         overflow;
  logic         dispatch_valid;
  tag_t         dispatch_tag;
  level_t       active_level;
  logic         idle;

  sched_tracker tracker = new();
  int           sent = 0;
  bit           send_calm = 0;
  int           quiet = 0;

  preemptive_priority_request_scheduler u_top (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .operation      (operation),
    .priority_req   (priority_req),
    .request_tag    (request_tag),
    .handlers_done  (handlers_done),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .cancel_running (cancel_running),
    .dropped        (dropped),
    .overflow       (overflow),
    .dispatch_valid (dispatch_valid),
    .dispatch_tag   (dispatch_tag),
    .active_level   (active_level),
    .idle           (idle)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      tracker.check_response({cancel_running, dropped, overflow, dispatch_valid,
                              dispatch_tag, active_level, idle});
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("[preemptive_priority_request_scheduler] ERROR");
        $finish;
      end
    end
  end

  // Drives one request beat; returns right after the edge that accepts it.
  task automatic send_beat(logic op, level_t prio, tag_t tag, logic hdone);
    int gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    priority_req = prio;
    request_tag = tag;
    handlers_done = hdone;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    tracker.note_request(op, prio, tag, hdone);
    sent++;
  endtask

  // Fields that a beat does not use still get random values.
  task automatic submit(level_t prio, tag_t tag);
    send_beat(OP_SUBMIT, prio, tag, 1'($urandom_range(0, 1)));
  endtask

  task automatic tick(logic hdone);
    send_beat(OP_TICK, level_t'($urandom_range(0, 3)), tag_t'($urandom_range(0, 65535)),
              hdone);
  endtask

  task automatic mixed_beat();
    int r;
    level_t p;
    if ($urandom_range(0, 99) < 45) begin
      tick($urandom_range(0, 4) != 0);
    end else begin
      r = $urandom_range(0, 99);
      p = (r < 8) ? LVL_HIGHEST : (r < 38) ? LVL_HIGH : (r < 75) ? LVL_NORMAL : LVL_BACKGROUND;
      submit(p, tag_t'($urandom_range(0, 65535)));
    end
  endtask

  task automatic directed_part();
    tick(1'b0);
    tick(1'b1);
    submit(LVL_BACKGROUND, 16'hFFFF);
    tick(1'b1);
    submit(LVL_NORMAL, 16'h0000);
    submit(LVL_HIGH, 16'h8000);
    tick(1'b1);
    submit(LVL_HIGH, 16'h0001);
    submit(LVL_NORMAL, 16'h7FFF);
    tick(1'b0);
    tick(1'b1);
    tick(1'b1);
    tick(1'b1);
    tick(1'b1);
    submit(LVL_HIGHEST, 16'h1234);
    submit(LVL_HIGH, 16'hAAAA);
    submit(LVL_NORMAL, 16'h5555);
    tick(1'b1);
    // Highest level is now active, so every lower submit is turned away.
    submit(LVL_HIGH, 16'h0F0F);
    submit(LVL_NORMAL, 16'hF0F0);
    submit(LVL_BACKGROUND, 16'h3C3C);
    submit(LVL_HIGHEST, 16'hFFFF);
    tick(1'b1);
    tick(1'b1);
  endtask

  task automatic random_part(int target);
    int kind;
    level_t p;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        repeat ($urandom_range(1, 12)) mixed_beat();
      end else if (kind == 6) begin
        // Fill one FIFO up to or past its depth. Lower levels first need highest drained.
        p = level_t'($urandom_range(0, 2));
        if (p != LVL_HIGHEST) repeat (QUEUE_DEPTH + 1) tick(1'b1);
        repeat ($urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 3)) begin
          submit(p, tag_t'($urandom_range(0, 65535)));
        end
      end else if (kind == 7) begin
        repeat ($urandom_range(3, 20)) tick($urandom_range(0, 7) != 0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_beat(1'($urandom_range(0, 1)), level_t'($urandom_range(0, 3)),
                    tag_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    bit calm;
    int gap;
    calm = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (gap > 0) begin
        rsp_stall = 1'b1;
        repeat (gap) @(negedge clk);
        rsp_stall = 1'b0;
      end
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed_part();
    random_part(sent + 850);
    @(negedge clk);
    req_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("[preemptive_priority_request_scheduler] OK");
    end else begin
      $display("[preemptive_priority_request_scheduler] ERROR");
    end
    $finish;
  end

endmodule
